>>> src/pttbl_pkg.sv
package pttbl_pkg;

   // operation codes
   localparam logic [1:0] MODE_OBSERVE = 2'd0;
   localparam logic [1:0] MODE_SATISFY = 2'd1;
   localparam logic [1:0] MODE_PEEK    = 2'd2;

   // shared divider widths
   localparam int DIV_NUM_W = 48;
   localparam int DIV_DEN_W = 32;
   localparam int DIV_CNT_W = 6;

   localparam logic [10:0] CONF_ONE       = 11'd1024;
   localparam logic [16:0] DEFICIT_Q_MAX  = 17'd65536;
   localparam logic [26:0] SCORE_ROUNDING = 27'd750;

   // divide by 1500 as multiply by ceil(2^38/1500), exact for 27-bit sums
   localparam logic [27:0] SCORE_RECIP    = 28'd183251938;
   localparam int          SCORE_SHIFT    = 38;

   // one table entry
   typedef struct packed {
      logic [63:0]        key;
      logic [31:0]        obs;
      logic [31:0]        unres;
      logic [31:0]        lowc;
      logic [41:0]        deficit;
      logic signed [31:0] newest_ord;
      logic [16:0]        priority_q;
   } entry_rec_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_DECIDE,
      ST_UPD,
      ST_DIV_DEF_GO,
      ST_DIV_DEF_WAIT,
      ST_SCORE,
      ST_PRI_MUL,
      ST_PRI_SET,
      ST_WRITE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_DONE
   } state_type;

endpackage

>>> src/priority_scored_topic_table.sv
// sequence: observe scans the held entries (a read state and a compare state per entry),
//   then runs one 48-step pass of the bit-serial divider; peek scans only;
//   satisfy scans, then does one read and one write per moved entry
// throughput: one item at a time; busy stays high until the result strobe
// reset: synchronous, clears the entry count and sets the threshold to 666; table contents kept
// the result is shown for one cycle; the receiver cannot stall
module priority_scored_topic_table
   import pttbl_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_mode,
   input  logic [63:0]        req_topic_key,
   input  logic               req_resolved,
   input  logic [10:0]        req_confidence,
   input  logic signed [31:0] req_order,
   output logic               rsp_valid,
   output logic               rsp_hit,
   output logic [63:0]        rsp_entry_key,
   output logic [16:0]        rsp_priority_res,
   output logic [31:0]        rsp_observation_count,
   output logic [31:0]        rsp_unres_count,
   output logic [31:0]        rsp_low_conf_count,
   output logic signed [31:0] rsp_latest_order,
   output logic [4:0]         rsp_entry_count,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [10:0]        csr_low_conf_threshold
);

   localparam int IW        = $clog2(TABLE_ENTRIES);
   localparam int CW        = $clog2(TABLE_ENTRIES + 1);
   localparam int REC_PAD_W = $bits(entry_rec_type) - 64;

   state_type state_ff, state_in;

   logic [CW-1:0]      vc_ff;
   logic [10:0]        thr_ff;
   logic [1:0]         mode_ff;
   logic [63:0]        key_ff;
   logic               resolved_ff;
   logic [10:0]        conf_ff;
   logic signed [31:0] order_ff;

   logic [CW-1:0]      scan_ff;
   logic               found_ff;
   logic [IW-1:0]      match_ff;
   logic [IW-1:0]      min_idx_ff;
   logic [16:0]        min_pri_ff;
   logic [16:0]        best_pri_ff;
   logic signed [31:0] best_ord_ff;
   logic [IW-1:0]      slot_ff;
   logic [IW-1:0]      j_ff;
   entry_rec_type      rec_ff;
   logic [16:0]        d_ff;
   logic [26:0]        num_ff;
   logic [54:0]        prod_ff;

   logic               rsp_valid_ff;
   logic               rsp_hit_ff;
   entry_rec_type      rsp_rec_ff;
   logic [4:0]         rsp_count_ff;

   // memory and divider hookup
   logic                 mem_we;
   logic [IW-1:0]        mem_waddr;
   logic [IW-1:0]        mem_raddr;
   entry_rec_type        mem_wdata;
   entry_rec_type        mem_rdata;
   logic                 div_start;
   logic [DIV_NUM_W-1:0] div_dividend;
   logic [DIV_DEN_W-1:0] div_divisor;
   logic                 div_done;
   logic [DIV_NUM_W-1:0] div_quotient;

   logic [CW-1:0] scan_nx;
   logic [CW-1:0] vc_dec;
   logic          scan_last;
   logic          accept;

   assign accept    = start && (state_ff == ST_IDLE);
   assign scan_nx   = scan_ff + 1'b1;
   assign scan_last = scan_nx == vc_ff;
   assign vc_dec    = vc_ff - 1'b1;

   pttbl_mem #(.DEPTH(TABLE_ENTRIES)) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   pttbl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (vc_ff == '0) ? ST_DECIDE : ST_SCAN_RD;
            end
         end
         ST_SCAN_RD:  state_in = ST_SCAN_CMP;
         ST_SCAN_CMP: state_in = scan_last ? ST_DECIDE : ST_SCAN_RD;
         ST_DECIDE: begin
            if (mode_ff == MODE_OBSERVE) begin
               state_in = ST_UPD;
            end else if (mode_ff == MODE_SATISFY && found_ff &&
                         (CW'(match_ff) + 1'b1) < vc_ff) begin
               state_in = ST_SHIFT_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_UPD:          state_in = ST_DIV_DEF_GO;
         ST_DIV_DEF_GO:   state_in = ST_DIV_DEF_WAIT;
         ST_DIV_DEF_WAIT: state_in = div_done ? ST_SCORE : ST_DIV_DEF_WAIT;
         ST_SCORE:        state_in = ST_PRI_MUL;
         ST_PRI_MUL:      state_in = ST_PRI_SET;
         ST_PRI_SET:      state_in = ST_WRITE;
         ST_WRITE:        state_in = ST_DONE;
         ST_SHIFT_RD:     state_in = ST_SHIFT_WR;
         ST_SHIFT_WR: begin
            state_in = ((CW'(j_ff) + 2'd2) == vc_ff) ? ST_DONE : ST_SHIFT_RD;
         end
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // state-driven controls
   always_comb begin
      mem_we       = 1'b0;
      mem_waddr    = slot_ff;
      mem_wdata    = rec_ff;
      mem_raddr    = scan_ff[IW-1:0];
      div_start    = 1'b0;
      div_dividend = {rec_ff.deficit, 6'b0};
      div_divisor  = (rec_ff.obs == '0) ? 32'd1 : rec_ff.obs;
      unique case (state_ff)
         ST_DIV_DEF_GO: div_start = 1'b1;
         ST_WRITE: mem_we = 1'b1;
         ST_SHIFT_RD: mem_raddr = j_ff + 1'b1;
         ST_SHIFT_WR: begin
            mem_we    = 1'b1;
            mem_waddr = j_ff;
            mem_wdata = mem_rdata;
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vc_ff        <= '0;
         thr_ff       <= 11'd666;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= state_ff == ST_DONE;
         if (csr_valid && csr_ready) begin
            thr_ff <= csr_low_conf_threshold;
         end
         if (state_ff == ST_DECIDE && mode_ff == MODE_OBSERVE && !found_ff &&
             vc_ff < CW'(TABLE_ENTRIES)) begin
            vc_ff <= vc_ff + 1'b1;
         end
         if (state_ff == ST_DONE && mode_ff == MODE_SATISFY && found_ff) begin
            vc_ff <= vc_dec;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_ff     <= req_mode;
               key_ff      <= req_topic_key;
               resolved_ff <= req_resolved;
               conf_ff     <= (req_confidence > CONF_ONE) ? CONF_ONE : req_confidence;
               order_ff    <= req_order;
               scan_ff     <= '0;
               found_ff    <= 1'b0;
            end
         end
         // compare one stored entry
         ST_SCAN_CMP: begin
            scan_ff <= scan_nx;
            if (mode_ff != MODE_PEEK && !found_ff && mem_rdata.key == key_ff) begin
               found_ff <= 1'b1;
               match_ff <= scan_ff[IW-1:0];
               rec_ff   <= mem_rdata;
            end
            if (scan_ff == '0) begin
               min_idx_ff  <= '0;
               min_pri_ff  <= mem_rdata.priority_q;
               best_pri_ff <= mem_rdata.priority_q;
               best_ord_ff <= mem_rdata.newest_ord;
               if (mode_ff == MODE_PEEK) rec_ff <= mem_rdata;
            end else begin
               if (mem_rdata.priority_q < min_pri_ff) begin
                  min_idx_ff <= scan_ff[IW-1:0];
                  min_pri_ff <= mem_rdata.priority_q;
               end
               if (mem_rdata.priority_q > best_pri_ff ||
                   (mem_rdata.priority_q == best_pri_ff &&
                    mem_rdata.newest_ord > best_ord_ff)) begin
                  best_pri_ff <= mem_rdata.priority_q;
                  best_ord_ff <= mem_rdata.newest_ord;
                  if (mode_ff == MODE_PEEK) rec_ff <= mem_rdata;
               end
            end
         end
         // pick the slot for an observe and the first shift index for a satisfy
         ST_DECIDE: begin
            j_ff <= match_ff;
            if (found_ff) begin
               slot_ff <= match_ff;
            end else begin
               slot_ff <= (vc_ff < CW'(TABLE_ENTRIES)) ? vc_ff[IW-1:0] : min_idx_ff;
               if (mode_ff == MODE_OBSERVE) begin
                  rec_ff <= {key_ff, {REC_PAD_W{1'b0}}};
               end
            end
         end
         // counters, deficit and order
         ST_UPD: begin
            entry_rec_type upd;
            logic [42:0]   dsum;
            upd = rec_ff;
            if (rec_ff.obs != '1) upd.obs = rec_ff.obs + 1'b1;
            if (!resolved_ff && rec_ff.unres != '1) begin
               upd.unres = rec_ff.unres + 1'b1;
            end
            if ((!resolved_ff || conf_ff < thr_ff) && rec_ff.lowc != '1) begin
               upd.lowc = rec_ff.lowc + 1'b1;
            end
            dsum = {1'b0, rec_ff.deficit} + 43'(CONF_ONE - conf_ff);
            upd.deficit = dsum[42] ? '1 : dsum[41:0];
            if (order_ff > rec_ff.newest_ord) upd.newest_ord = order_ff;
            rec_ff <= upd;
         end
         ST_DIV_DEF_WAIT: begin
            if (div_done) begin
               d_ff <= (div_quotient > DIV_NUM_W'(DEFICIT_Q_MAX)) ?
                       DEFICIT_Q_MAX : div_quotient[16:0];
            end
         end
         // weighted sum ahead of the divide by 1500
         ST_SCORE: begin
            logic [1:0]  u;
            logic [2:0]  o;
            logic [1:0]  l;
            logic        r;
            logic [10:0] w;
            u = (rec_ff.unres > 32'd3) ? 2'd3 : rec_ff.unres[1:0];
            o = (rec_ff.obs > 32'd5) ? 3'd5 : rec_ff.obs[2:0];
            l = (rec_ff.lowc > 32'd3) ? 2'd3 : rec_ff.lowc[1:0];
            r = rec_ff.newest_ord > 32'sd0;
            w = 11'd150 * u + 11'd72 * o + 11'd80 * l + (r ? 11'd150 : 11'd0);
            num_ff <= {w, 16'b0} + 27'(d_ff) * 27'd300 + SCORE_ROUNDING;
         end
         // divide by 1500 through the reciprocal
         ST_PRI_MUL: prod_ff <= 55'(num_ff) * 55'(SCORE_RECIP);
         ST_PRI_SET: rec_ff.priority_q <= prod_ff[SCORE_SHIFT +: 17];
         ST_SHIFT_WR: j_ff <= j_ff + 1'b1;
         // result register
         ST_DONE: begin
            rsp_count_ff <= (mode_ff == MODE_SATISFY && found_ff) ? 5'(vc_dec) : 5'(vc_ff);
            case (mode_ff)
               MODE_OBSERVE: begin
                  rsp_hit_ff <= 1'b1;
                  rsp_rec_ff <= rec_ff;
               end
               MODE_SATISFY: begin
                  if (found_ff) begin
                     rsp_hit_ff <= 1'b1;
                     rsp_rec_ff <= rec_ff;
                  end else begin
                     rsp_hit_ff <= 1'b0;
                     rsp_rec_ff <= {key_ff, {REC_PAD_W{1'b0}}};
                  end
               end
               MODE_PEEK: begin
                  if (vc_ff != '0) begin
                     rsp_hit_ff <= 1'b1;
                     rsp_rec_ff <= rec_ff;
                  end else begin
                     rsp_hit_ff <= 1'b0;
                     rsp_rec_ff <= '0;
                  end
               end
               default: begin
                  rsp_hit_ff <= 1'b0;
                  rsp_rec_ff <= '0;
               end
            endcase
         end
         default: ;
      endcase
   end

   assign busy                  = state_ff != ST_IDLE;
   assign csr_ready             = state_ff == ST_IDLE;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_hit               = rsp_hit_ff;
   assign rsp_entry_key         = rsp_rec_ff.key;
   assign rsp_priority_res      = rsp_rec_ff.priority_q;
   assign rsp_observation_count = rsp_rec_ff.obs;
   assign rsp_unres_count       = rsp_rec_ff.unres;
   assign rsp_low_conf_count    = rsp_rec_ff.lowc;
   assign rsp_latest_order      = rsp_rec_ff.newest_ord;
   assign rsp_entry_count       = rsp_count_ff;

endmodule

>>> src/pttbl_mem.sv
module pttbl_mem
   import pttbl_pkg::*;
#(
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  entry_rec_type wdata,
   input  logic [AW-1:0] raddr,
   output entry_rec_type rdata
);

   entry_rec_type mem_ff [DEPTH];
   entry_rec_type rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> src/pttbl_div.sv
module pttbl_div
   import pttbl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] dividend,
   input  logic [DIV_DEN_W-1:0] divisor,
   output logic                 done,
   output logic [DIV_NUM_W-1:0] quotient
);

   logic                 run_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_DEN_W:0]   rem_ff;
   logic [DIV_NUM_W-1:0] quo_ff;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_DEN_W:0]   rem_sh;
   logic                 fits;

   // one restoring step per cycle
   always_comb begin
      rem_sh = {rem_ff[DIV_DEN_W-1:0], quo_ff[DIV_NUM_W-1]};
      fits   = rem_sh >= {1'b0, den_ff};
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         den_ff <= divisor;
      end else if (run_ff) begin
         rem_ff <= fits ? rem_sh - {1'b0, den_ff} : rem_sh;
         quo_ff <= {quo_ff[DIV_NUM_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> src/pttbl_chk.sv
module pttbl_chk #(
   parameter int TABLE_ENTRIES = 16
) (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_hit,
   input logic [31:0] rsp_observation_count,
   input logic [4:0]  rsp_entry_count
);

   // an accepted item holds the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("item accepted but block not busy");

   // a result only follows a busy period
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without an item in flight");

   // a miss carries no entry counters, a hit always an observed entry
   a_hit_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hit == (rsp_observation_count != 32'd0)))
      else $error("hit flag disagrees with observation count");

   // entry count within table size
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (TABLE_ENTRIES > 31 || rsp_entry_count <= 5'(TABLE_ENTRIES)))
      else $error("entry count beyond table size");

endmodule

bind priority_scored_topic_table pttbl_chk #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_pttbl_chk (
   .clock                 (clock),
   .reset                 (reset),
   .start                 (start),
   .busy                  (busy),
   .rsp_valid             (rsp_valid),
   .rsp_hit               (rsp_hit),
   .rsp_observation_count (rsp_observation_count),
   .rsp_entry_count       (rsp_entry_count)
);

>>> sim/priority_scored_topic_table_test.sv
module priority_scored_topic_table_test;
   import pttbl_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          ENTRIES     = 16;
   localparam logic [1:0]  MODE_UNUSED = 2'd3;
   localparam int          CYCLE_LIMIT = 2000000;
   localparam int          KEY_POOL    = 22;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_mode = MODE_PEEK;
   logic [63:0]        req_topic_key = '0;
   logic               req_resolved = 1'b0;
   logic [10:0]        req_confidence = '0;
   logic signed [31:0] req_order = '0;
   logic               rsp_valid;
   logic               rsp_hit;
   logic [63:0]        rsp_entry_key;
   logic [16:0]        rsp_priority_res;
   logic [31:0]        rsp_observation_count;
   logic [31:0]        rsp_unres_count;
   logic [31:0]        rsp_low_conf_count;
   logic signed [31:0] rsp_latest_order;
   logic [4:0]         rsp_entry_count;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [10:0]        csr_low_conf_threshold = '0;

   typedef struct {
      bit               hit;
      bit [63:0]        key;
      bit [16:0]        prio;
      bit [31:0]        obs;
      bit [31:0]        unres;
      bit [31:0]        lowc;
      bit signed [31:0] newest_ord;
      bit [4:0]         count;
   } topic_result_type;

   // table predictor with its queue of awaited results
   class topic_board_type;
      bit [63:0]        keys[ENTRIES];
      bit [31:0]        obs[ENTRIES];
      bit [31:0]        unres[ENTRIES];
      bit [31:0]        lowc[ENTRIES];
      bit [41:0]        deficit[ENTRIES];
      bit signed [31:0] newest_ord[ENTRIES];
      bit [16:0]        prio[ENTRIES];
      int               used;
      bit [10:0]        threshold;
      topic_result_type awaited[$];
      int               errors;
      int               checked;
      int               hits;
      int               evictions;

      function new();
         used = 0;
         threshold = 11'd666;
         errors = 0;
         checked = 0;
         hits = 0;
         evictions = 0;
      endfunction

      function void wipe(int i);
         keys[i] = '0; obs[i] = '0; unres[i] = '0; lowc[i] = '0;
         deficit[i] = '0; newest_ord[i] = '0; prio[i] = '0;
      endfunction

      function bit [16:0] score(int i);
         longint unsigned o, u, l, r, n, d, num;
         o = obs[i] > 5 ? 5 : obs[i];
         u = unres[i] > 3 ? 3 : unres[i];
         l = lowc[i] > 3 ? 3 : lowc[i];
         r = newest_ord[i] > 0 ? 1 : 0;
         n = obs[i] != 0 ? obs[i] : 1;
         d = (longint'(deficit[i]) * 64) / n;
         if (d > 65536) d = 65536;
         num = 65536 * (150 * u + 72 * o + 80 * l + 150 * r) + 300 * d + 750;
         return 17'(num / 1500);
      endfunction

      function topic_result_type entry_view(bit hit, int i, bit have);
         topic_result_type t;
         t.hit = hit;
         t.key = have ? keys[i] : '0;
         t.prio = have ? prio[i] : '0;
         t.obs = have ? obs[i] : '0;
         t.unres = have ? unres[i] : '0;
         t.lowc = have ? lowc[i] : '0;
         t.newest_ord = have ? newest_ord[i] : '0;
         t.count = 5'(used);
         return t;
      endfunction

      function int find_key(bit [63:0] key);
         for (int i = 0; i < used; i++)
            if (keys[i] == key) return i;
         return -1;
      endfunction

      // accepted item: update the table and queue its result
      function void note_item(bit [1:0] mode, bit [63:0] key, bit resolved,
                              bit [10:0] conf_in, bit signed [31:0] ord);
         topic_result_type t;
         int               slot;
         bit [10:0]        conf;
         bit [42:0]        sum;
         conf = conf_in > 11'd1024 ? 11'd1024 : conf_in;
         t = entry_view(1'b0, 0, 1'b0);
         case (mode)
            MODE_OBSERVE: begin
               slot = find_key(key);
               if (slot < 0) begin
                  if (used < ENTRIES) begin
                     slot = used;
                     used++;
                  end else begin
                     slot = 0;
                     for (int i = 1; i < used; i++)
                        if (prio[i] < prio[slot]) slot = i;
                     evictions++;
                  end
                  wipe(slot);
                  keys[slot] = key;
               end
               if (obs[slot] != '1) obs[slot]++;
               if (!resolved && unres[slot] != '1) unres[slot]++;
               if ((!resolved || conf < threshold) && lowc[slot] != '1) lowc[slot]++;
               sum = deficit[slot] + (11'd1024 - conf);
               deficit[slot] = sum[42] ? '1 : sum[41:0];
               if (ord > newest_ord[slot]) newest_ord[slot] = ord;
               prio[slot] = score(slot);
               t = entry_view(1'b1, slot, 1'b1);
            end
            MODE_SATISFY: begin
               slot = find_key(key);
               if (slot >= 0) begin
                  t = entry_view(1'b1, slot, 1'b1);
                  for (int j = slot; j + 1 < used; j++) begin
                     keys[j] = keys[j+1]; obs[j] = obs[j+1]; unres[j] = unres[j+1];
                     lowc[j] = lowc[j+1]; deficit[j] = deficit[j+1];
                     newest_ord[j] = newest_ord[j+1]; prio[j] = prio[j+1];
                  end
                  used--;
                  wipe(used);
                  t.count = 5'(used);
                  hits++;
               end else begin
                  t.key = key;
               end
            end
            MODE_PEEK: begin
               if (used > 0) begin
                  slot = 0;
                  for (int i = 1; i < used; i++)
                     if (prio[i] > prio[slot] ||
                         (prio[i] == prio[slot] && newest_ord[i] > newest_ord[slot]))
                        slot = i;
                  t = entry_view(1'b1, slot, 1'b1);
               end
            end
            default: ;
         endcase
         awaited.push_back(t);
      endfunction

      task report(string what, longint got, longint want);
         errors++;
         $display("mismatch on item %0d: %s got %0h expected %0h", checked, what, got, want);
      endtask

      // result strobe: compare against the oldest awaited item
      task check_result(topic_result_type got);
         topic_result_type want;
         checked++;
         if (awaited.size() == 0) begin
            report("unexpected result, hit", got.hit, 0);
            return;
         end
         want = awaited.pop_front();
         if (got.hit != want.hit) report("hit", got.hit, want.hit);
         if (got.key != want.key) report("entry_key", got.key, want.key);
         if (got.prio != want.prio) report("priority_res", got.prio, want.prio);
         if (got.obs != want.obs) report("observation_count", got.obs, want.obs);
         if (got.unres != want.unres) report("unres_count", got.unres, want.unres);
         if (got.lowc != want.lowc) report("low_conf_count", got.lowc, want.lowc);
         if (got.newest_ord != want.newest_ord)
            report("latest_order", got.newest_ord, want.newest_ord);
         if (got.count != want.count) report("entry_count", got.count, want.count);
      endtask
   endclass

   topic_board_type  board = new();
   bit [63:0]        key_pool[KEY_POOL];
   int               cycles = 0;
   int               burst_left = 0;

   priority_scored_topic_table #(.TABLE_ENTRIES(ENTRIES)) dut (.*);

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // result monitor and run limit
   always @(posedge clock) begin
      topic_result_type got;
      cycles <= cycles + 1;
      if (!reset && rsp_valid) begin
         got.hit = rsp_hit;
         got.key = rsp_entry_key;
         got.prio = rsp_priority_res;
         got.obs = rsp_observation_count;
         got.unres = rsp_unres_count;
         got.lowc = rsp_low_conf_count;
         got.newest_ord = rsp_latest_order;
         got.count = rsp_entry_count;
         board.check_result(got);
      end
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("simulation failed");
         $finish;
      end
   end

   // one item on the request side, with bursts and gaps between them
   task send_item(bit [1:0] mode, bit [63:0] key, bit resolved, bit [10:0] conf,
                  bit signed [31:0] ord);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start <= 1'b1;
      req_mode <= mode;
      req_topic_key <= key;
      req_resolved <= resolved;
      req_confidence <= conf;
      req_order <= ord;
      do @(posedge clock); while (busy);
      board.note_item(mode, key, resolved, conf, ord);
   endtask

   // threshold write with the block idle
   task write_threshold(bit [10:0] value);
      start <= 1'b0;
      burst_left = 0;
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      csr_valid <= 1'b1;
      csr_low_conf_threshold <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.threshold = value;
   endtask

   task random_item();
      bit [1:0]         mode;
      bit [63:0]        key;
      bit [10:0]        conf;
      bit signed [31:0] ord;
      int               pick;
      pick = $urandom_range(0, 99);
      mode = pick < 55 ? MODE_OBSERVE : pick < 75 ? MODE_SATISFY :
             pick < 96 ? MODE_PEEK : MODE_UNUSED;
      key = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                        : key_pool[$urandom_range(0, KEY_POOL - 1)];
      conf = ($urandom_range(0, 7) == 0) ? 11'($urandom_range(1025, 2047))
                                         : 11'($urandom_range(0, 1024));
      ord = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 8)) - 3 : $urandom;
      send_item(mode, key, 1'($urandom), conf, ord);
   endtask

   initial begin
      bit [10:0] settings[5];
      settings = '{11'd0, 11'd1024, 11'd2047, 11'd666, 11'd0};
      settings[4] = 11'($urandom_range(1, 1023));
      foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
      key_pool[0] = '0;
      key_pool[1] = '1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, extremes, fill past capacity, removal
      send_item(MODE_PEEK, 64'h0, 1'b0, 11'd0, 32'sd0);
      send_item(MODE_SATISFY, 64'h1234, 1'b0, 11'd0, 32'sd0);
      send_item(MODE_UNUSED, '1, 1'b1, 11'd2047, '1);
      send_item(MODE_OBSERVE, 64'h0, 1'b0, 11'd0, 32'sh7fffffff);
      send_item(MODE_OBSERVE, '1, 1'b1, 11'd2047, 32'sh80000000);
      send_item(MODE_OBSERVE, '1, 1'b1, 11'd1024, 32'sd0);
      send_item(MODE_OBSERVE, 64'h0, 1'b1, 11'd665, -32'sd1);
      send_item(MODE_PEEK, 64'h0, 1'b0, 11'd0, 32'sd0);
      for (int i = 2; i < 19; i++)
         send_item(MODE_OBSERVE, key_pool[i], 1'b1, 11'd1024, 32'(i % 3));
      send_item(MODE_PEEK, 64'h0, 1'b0, 11'd0, 32'sd0);
      send_item(MODE_SATISFY, key_pool[5], 1'b0, 11'd0, 32'sd0);
      send_item(MODE_SATISFY, key_pool[5], 1'b0, 11'd0, 32'sd0);

      // random phases, each under its own threshold
      foreach (settings[p]) begin
         write_threshold(settings[p]);
         repeat (290) random_item();
      end

      start <= 1'b0;
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("%0d results checked over five thresholds, %0d removals, %0d replacements",
               board.checked, board.hits, board.evictions);
      if (board.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> files.f
src/pttbl_pkg.sv
src/pttbl_mem.sv
src/pttbl_div.sv
src/priority_scored_topic_table.sv
src/pttbl_chk.sv
sim/priority_scored_topic_table_test.sv
